/* rtl/ttb_pkg.sv */
package ttb_pkg;

  // corner and result field widths
  localparam int IN_W  = 32;
  localparam int OUT_W = 16;

  // output fraction bits
  localparam int OUT_FRAC_BITS = 14;

  // differences of two corners, products of two differences
  localparam int DIFF_W = IN_W + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // normalised magnitude, square sum and root
  localparam int NRM_W  = 30;
  localparam int MAG_W  = PROD_W - 1;
  localparam int SUM_W  = 2 * NRM_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  // rounded dividend and quotient
  localparam int NUM_W = NRM_W + OUT_FRAC_BITS + 1;
  localparam int QUO_W = OUT_FRAC_BITS + 2;

  localparam logic [QUO_W-1:0] Q_SAT = QUO_W'(32767);

  typedef logic signed [IN_W-1:0]   in_word_t;
  typedef logic signed [OUT_W-1:0]  out_word_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

/* rtl/ttb_if.sv */
interface ttb_in_if;
  logic              valid;
  logic              ready;
  ttb_pkg::in_word_t pos_x;
  ttb_pkg::in_word_t pos_y;
  ttb_pkg::in_word_t pos_z;
  ttb_pkg::in_word_t tex_u;
  ttb_pkg::in_word_t tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_out_if;
  logic               valid;
  logic               ready;
  ttb_pkg::out_word_t tangent_x;
  ttb_pkg::out_word_t tangent_y;
  ttb_pkg::out_word_t tangent_z;
  ttb_pkg::out_word_t bitangent_x;
  ttb_pkg::out_word_t bitangent_y;
  ttb_pkg::out_word_t bitangent_z;
  logic               degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, output ready);
endinterface

/* rtl/triangle_tangent_basis.sv */
// triangle tangent basis: takes one triangle corner per request (position and
// texture coordinate, signed q16.16) and on every third corner returns the unit
// tangent and bitangent of that triangle in signed fixed point with
// OUT_FRAC_BITS fraction bits, plus a degenerate flag when the uv determinant is
// zero (vectors then zero). the first two corners of a triangle are only stored
// and give no result. the third corner runs through a sequencer that drives one
// shared 33x33 multiplier (14 products, then 3 squares per vector), a bit-serial
// square root and a bit-serial divider, with a normalising shifter per vector
// in between; a degenerate triangle skips the shifter, root and divider, and a
// zero vector skips its own shift, root and divide. the block stays busy until
// the result goes into the output register, and in_ch.ready is low meanwhile.
// the result sits in an output register, so the next triangle's corners are
// taken while it waits.
module triangle_tangent_basis (
  input  logic      clk,
  input  logic      rst_n,
  ttb_in_if.sink    in_ch,
  ttb_out_if.source out_ch
);
  import ttb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_PROD, S_CHKDET, S_NLOAD, S_NSHIFT, S_SQ,
    S_SQRT, S_DIVGO, S_DIVWAIT, S_NEXTV, S_EMIT
  } state_t;

  state_t state_r;

  // corner store
  logic [1:0] cnt_r;
  in_word_t   hp_r [6];
  in_word_t   ht_r [4];
  in_word_t   cp_r [3];
  in_word_t   cu_r;
  in_word_t   cv_r;
  logic [2:0] hp_base;

  // edges and uv deltas
  diff_t e1_r [3];
  diff_t e2_r [3];
  diff_t du1_r, dv1_r, du2_r, dv2_r;

  // det, tangent xyz, bitangent xyz
  prod_t      res_r [7];
  prod_t      acc_r;
  logic [3:0] step_r;

  // normalisation
  logic             vec_r;
  logic [MAG_W-1:0] mag_r [3];
  logic [2:0]       neg_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sq_sum;
  logic [1:0]       comp_r;
  logic [ROOT_W-1:0] len_r;

  // result
  out_word_t res_out_r [6];
  logic      degen_r;
  logic      out_valid_r;
  out_word_t o_r [6];
  logic      o_degen_r;

  // shared unit
  diff_t mul_a, mul_b;
  prod_t prod;
  logic  sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic  div_start, div_done;
  logic [QUO_W-1:0] quo;
  logic [NUM_W-1:0] dividend;
  logic [MAG_W-1:0] mag_or;
  logic [MAG_W-1:0] cur_mag;
  logic             flip;
  logic [QUO_W-1:0] q_sat;
  out_word_t        q_signed;
  logic [2:0]       base;

  ttb_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  ttb_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sq_sum),
    .done(sqrt_done), .root(sqrt_root)
  );

  ttb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dividend),
    .divisor(len_r), .done(div_done), .quotient(quo)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      case (step_r[1:0])
        2'd0:    mul_a = DIFF_W'(mag_r[0][NRM_W-1:0]);
        2'd1:    mul_a = DIFF_W'(mag_r[1][NRM_W-1:0]);
        default: mul_a = DIFF_W'(mag_r[2][NRM_W-1:0]);
      endcase
      mul_b = mul_a;
    end else begin
      case (step_r)
        4'd0:    begin mul_a = du1_r; mul_b = dv2_r;    end
        4'd1:    begin mul_a = dv1_r; mul_b = du2_r;    end
        4'd2:    begin mul_a = dv2_r; mul_b = e1_r[0];  end
        4'd3:    begin mul_a = dv1_r; mul_b = e2_r[0];  end
        4'd4:    begin mul_a = dv2_r; mul_b = e1_r[1];  end
        4'd5:    begin mul_a = dv1_r; mul_b = e2_r[1];  end
        4'd6:    begin mul_a = dv2_r; mul_b = e1_r[2];  end
        4'd7:    begin mul_a = dv1_r; mul_b = e2_r[2];  end
        4'd8:    begin mul_a = du1_r; mul_b = e2_r[0];  end
        4'd9:    begin mul_a = du2_r; mul_b = e1_r[0];  end
        4'd10:   begin mul_a = du1_r; mul_b = e2_r[1];  end
        4'd11:   begin mul_a = du2_r; mul_b = e1_r[1];  end
        4'd12:   begin mul_a = du1_r; mul_b = e2_r[2];  end
        4'd13:   begin mul_a = du2_r; mul_b = e1_r[2];  end
        default: begin mul_a = '0;    mul_b = '0;       end
      endcase
    end
  end

  assign sqrt_start = (state_r == S_SQ) && (step_r == 4'd3);
  assign div_start  = (state_r == S_DIVGO);
  assign mag_or     = mag_r[0] | mag_r[1] | mag_r[2];
  assign base       = vec_r ? 3'd4 : 3'd1;
  assign hp_base    = cnt_r[0] ? 3'd3 : 3'd0;

  // square sum including the last square, taken by the root unit at its start
  assign sq_sum = sum_r + SUM_W'(prod);

  always_comb begin
    case (comp_r)
      2'd0:    begin cur_mag = mag_r[0]; flip = neg_r[0]; end
      2'd1:    begin cur_mag = mag_r[1]; flip = neg_r[1]; end
      default: begin cur_mag = mag_r[2]; flip = neg_r[2]; end
    endcase
  end

  // rounded dividend: m * 2^frac + len/2
  assign dividend = {1'b0, cur_mag[NRM_W-1:0], {OUT_FRAC_BITS{1'b0}}}
                  + NUM_W'(len_r >> 1);

  // saturate, then apply component sign and determinant sign
  assign q_sat    = (quo > Q_SAT) ? Q_SAT : quo;
  assign q_signed = (flip ^ res_r[0][PROD_W-1]) ? -OUT_W'(q_sat) : OUT_W'(q_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      // output register drains; a new result in S_EMIT takes its place
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (cnt_r == 2'd2) begin
              cp_r[0] <= in_ch.pos_x;
              cp_r[1] <= in_ch.pos_y;
              cp_r[2] <= in_ch.pos_z;
              cu_r    <= in_ch.tex_u;
              cv_r    <= in_ch.tex_v;
              cnt_r   <= '0;
              state_r <= S_DIFF;
            end else begin
              hp_r[hp_base]        <= in_ch.pos_x;
              hp_r[hp_base + 3'd1] <= in_ch.pos_y;
              hp_r[hp_base + 3'd2] <= in_ch.pos_z;
              ht_r[{cnt_r[0], 1'b0}]      <= in_ch.tex_u;
              ht_r[{cnt_r[0], 1'b1}]      <= in_ch.tex_v;
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            e1_r[i] <= DIFF_W'(hp_r[3+i]) - DIFF_W'(hp_r[i]);
            e2_r[i] <= DIFF_W'(cp_r[i]) - DIFF_W'(hp_r[i]);
          end
          du1_r   <= DIFF_W'(ht_r[2]) - DIFF_W'(ht_r[0]);
          dv1_r   <= DIFF_W'(ht_r[3]) - DIFF_W'(ht_r[1]);
          du2_r   <= DIFF_W'(cu_r) - DIFF_W'(ht_r[0]);
          dv2_r   <= DIFF_W'(cv_r) - DIFF_W'(ht_r[1]);
          step_r  <= '0;
          state_r <= S_PROD;
        end
        S_PROD: begin
          // product of the previous step is in prod
          if (step_r != 4'd0) begin
            if (!step_r[0]) begin
              res_r[3'((step_r - 4'd1) >> 1)] <= acc_r - prod;
            end else begin
              acc_r <= prod;
            end
          end
          if (step_r == 4'd14) begin
            state_r <= S_CHKDET;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_CHKDET: begin
          if (res_r[0] == '0) begin
            for (int i = 0; i < 6; i++) res_out_r[i] <= '0;
            degen_r <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            degen_r <= 1'b0;
            vec_r   <= 1'b0;
            state_r <= S_NLOAD;
          end
        end
        S_NLOAD: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= res_r[base + 3'(i)][PROD_W-1];
            mag_r[i] <= res_r[base + 3'(i)][PROD_W-1]
                        ? MAG_W'(-res_r[base + 3'(i)])
                        : MAG_W'(res_r[base + 3'(i)]);
          end
          state_r <= S_NSHIFT;
        end
        S_NSHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mag_or == '0) begin
            for (int i = 0; i < 3; i++) res_out_r[{vec_r, 1'b0} + 3'(vec_r) + 3'(i)] <= '0;
            state_r <= S_NEXTV;
          end else if (|mag_or[MAG_W-1:NRM_W+8]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 8;
          end else if (|mag_or[MAG_W-1:NRM_W]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (mag_or[NRM_W-1:NRM_W-8] == '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 8;
          end else if (!mag_or[NRM_W-1]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            step_r  <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_r == 4'd1) begin
            sum_r <= SUM_W'(prod);
          end else if (step_r != 4'd0) begin
            sum_r <= sum_r + SUM_W'(prod);
          end
          if (step_r == 4'd3) begin
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            len_r   <= sqrt_root;
            comp_r  <= '0;
            state_r <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state_r <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            res_out_r[{vec_r, 1'b0} + 3'(vec_r) + 3'(comp_r)] <= q_signed;
            if (comp_r == 2'd2) begin
              state_r <= S_NEXTV;
            end else begin
              comp_r  <= comp_r + 1'b1;
              state_r <= S_DIVGO;
            end
          end
        end
        S_NEXTV: begin
          if (!vec_r) begin
            vec_r   <= 1'b1;
            state_r <= S_NLOAD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // wait for the output register to free up
          if (!out_valid_r || out_ch.ready) begin
            for (int i = 0; i < 6; i++) o_r[i] <= res_out_r[i];
            o_degen_r   <= degen_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.tangent_x   = o_r[0];
  assign out_ch.tangent_y   = o_r[1];
  assign out_ch.tangent_z   = o_r[2];
  assign out_ch.bitangent_x = o_r[3];
  assign out_ch.bitangent_y = o_r[4];
  assign out_ch.bitangent_z = o_r[5];
  assign out_ch.degenerate  = o_degen_r;
endmodule

/* rtl/ttb_mul.sv */
module ttb_mul (
  input  logic           clk,
  input  ttb_pkg::diff_t op_a,
  input  ttb_pkg::diff_t op_b,
  output ttb_pkg::prod_t prod
);
  import ttb_pkg::*;

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;
endmodule

/* rtl/ttb_isqrt.sv */
module ttb_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttb_pkg::SUM_W-1:0]   radicand,
  output logic                        done,
  output logic [ttb_pkg::ROOT_W-1:0]  root
);
  import ttb_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  src_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;

  // one result bit per cycle, two radicand bits brought down
  assign shifted = {rem_r[REM_W-3:0], src_r[SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        src_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        src_r <= {src_r[SUM_W-3:0], 2'b00};
        if (shifted >= trial) begin
          rem_r  <= shifted - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= shifted;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

/* rtl/ttb_div.sv */
module ttb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ttb_pkg::NUM_W-1:0]  dividend,
  input  logic [ttb_pkg::ROOT_W-1:0] divisor,
  output logic                       done,
  output logic [ttb_pkg::QUO_W-1:0]  quotient
);
  import ttb_pkg::*;

  localparam int REM_W = ROOT_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  low_r;
  logic [QUO_W-1:0]  quo_r;
  logic [ROOT_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  shifted;

  // the upper dividend bits are known to lie below the divisor
  assign shifted = {rem_r[REM_W-2:0], low_r[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= REM_W'(dividend[NUM_W-1:QUO_W]);
        low_r  <= dividend[QUO_W-1:0];
        quo_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        low_r <= {low_r[QUO_W-2:0], 1'b0};
        if (shifted >= REM_W'(dvs_r)) begin
          rem_r <= shifted - REM_W'(dvs_r);
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
